// ===== rtl/ccs_pkg.sv =====
// ----------------------------------------------------------------------------
// ccs_pkg
// shared types and constants of the character-class scan engine
// ----------------------------------------------------------------------------
package ccs_pkg;

    localparam int CHAR_COUNT  = 256;
    localparam int LITERAL_MAX = 16;
    localparam int SUBJECT_MAX = 4096;

    // fixed field widths
    localparam int OPCODE_W  = 2;
    localparam int CHAR_W    = 8;
    localparam int CLASS_W   = 3;
    localparam int LIT_IN_W  = 4;
    localparam int MODE_W    = 3;
    localparam int LITLEN_W  = 5;
    localparam int MLEN_W    = 13;
    localparam int DEPTH_W   = 13;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 5;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 13'd8191;

    // derived sizes
    localparam int TBL_IDX_W = (CHAR_COUNT > 1) ? $clog2(CHAR_COUNT) : 1;
    localparam int LIT_IDX_W = (LITERAL_MAX > 1) ? $clog2(LITERAL_MAX) : 1;
    localparam int POS_W     = $clog2(SUBJECT_MAX + 1);

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_WR_CLASS = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_WR_LIT   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_START    = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_SUBJECT  = 2'd3;

    // scan modes
    localparam logic [MODE_W-1:0] MODE_ANY   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SPAN  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BREAK = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BAL   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FIND  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_LIT   = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIT_LEN   = 1'b1;

    // class bit positions
    localparam int CLS_SCAN  = 0;
    localparam int CLS_OPEN  = 1;
    localparam int CLS_CLOSE = 2;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [CHAR_W-1:0]   char_code;
        logic [CLASS_W-1:0]  class_bits;
        logic [LIT_IN_W-1:0] lit_index;
        logic                at_end;
        logic                last;
    } cmd_item_t;

endpackage

// ===== rtl/ccs_if.sv =====
// ----------------------------------------------------------------------------
// ccs channel interfaces
// command channel and result channel, valid/ready with payload
// ----------------------------------------------------------------------------
interface ccs_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [ccs_pkg::OPCODE_W-1:0]  opcode;
    logic [ccs_pkg::CHAR_W-1:0]    char_code;
    logic [ccs_pkg::CLASS_W-1:0]   class_bits;
    logic [ccs_pkg::LIT_IN_W-1:0]  lit_index;
    logic                          at_end;
    logic                          last;

    modport source (output valid, opcode, char_code, class_bits, lit_index, at_end, last,
                    input ready);
    modport sink   (input valid, opcode, char_code, class_bits, lit_index, at_end, last,
                    output ready);
endinterface

interface ccs_result_if;
    logic                        valid;
    logic                        ready;
    logic                        success;
    logic [ccs_pkg::MLEN_W-1:0]  match_length;

    modport source (output valid, success, match_length, input ready);
    modport sink   (input valid, success, match_length, output ready);
endinterface

// ===== rtl/char_class_scan_engine.sv =====
// ----------------------------------------------------------------------------
// char_class_scan_engine
// one character-class scan primitive (any, span, break, bal, find, lit)
// ----------------------------------------------------------------------------
// The cmd channel carries class table writes, literal writes, scan starts and
// the subject characters from the cursor onward. At most one result per
// command leaves on the result channel: success and the match length from the
// cursor (zero on failure). scan_mode and literal_length are written through
// the cfg_write / cfg_index / cfg_data port; the user must write them only
// while the block is idle; the block does not enforce it. Throughput: one
// command per cycle unless the receiver stalls. A command transfer loads the
// input register and the class table read register together; any result is
// loaded into the result register when the input register advances. The rate
// is set by the single read port of the class table and the one registered
// pass between input register and result register. Reset clears the class
// table valid bits (all classes empty), the window, position, depth and flags,
// sets the scan to decided (idle) and loads scan_mode = span and
// literal_length = 0. The literal store is not cleared. When the receiver
// stalls, the result register holds; the input register still takes one more
// command, and cmd.ready then drops until the result has been taken.
// ----------------------------------------------------------------------------
module char_class_scan_engine
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [ccs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ccs_pkg::CFG_DAT_W-1:0]   cfg_data,
    ccs_cmd_if.sink                         cmd,
    ccs_result_if.source                    result
);

    localparam int LM = ccs_pkg::LITERAL_MAX;
    localparam int PW = ccs_pkg::POS_W;
    localparam int IW = ccs_pkg::LIT_IDX_W;

    // configuration
    logic [ccs_pkg::MODE_W-1:0]   scan_mode_reg;
    logic [ccs_pkg::LITLEN_W-1:0] literal_length_reg;

    // input stage
    logic                         s1_valid_reg;
    ccs_pkg::cmd_item_t           s1_item_reg;
    logic [ccs_pkg::CLASS_W-1:0]  cls_rd_reg;
    logic                         cls_vld_rd_reg;

    // stores
    logic [ccs_pkg::CLASS_W-1:0]  class_mem [ccs_pkg::CHAR_COUNT];
    logic [ccs_pkg::CHAR_COUNT-1:0] class_vld_reg;
    logic [ccs_pkg::CHAR_W-1:0]   lit_reg [LM];
    logic [ccs_pkg::CHAR_W-1:0]   window_reg [LM];
    logic [ccs_pkg::CHAR_W-1:0]   window_next [LM];

    // scan state
    logic [PW-1:0]                pos_reg, pos_next;
    logic [ccs_pkg::DEPTH_W-1:0]  depth_reg, depth_next;
    logic                         pending_reg, pending_next;
    logic                         decided_reg, decided_next;

    // result register
    logic                         out_valid_reg;
    logic                         out_success_reg;
    logic [ccs_pkg::MLEN_W-1:0]   out_len_reg;

    logic                         accept;
    logic                         adv;
    logic                         emit;
    logic                         emit_ok;
    logic [PW-1:0]                emit_len;
    logic                         char_in_range;
    logic                         lit_in_range;
    logic [ccs_pkg::TBL_IDX_W-1:0] tbl_idx;
    logic [IW-1:0]                lit_wr_idx;

    assign accept        = cmd.valid && cmd.ready;
    assign adv           = s1_valid_reg && (!out_valid_reg || result.ready);
    assign cmd.ready     = !s1_valid_reg || adv;
    assign tbl_idx       = cmd.char_code[ccs_pkg::TBL_IDX_W-1:0];
    assign char_in_range = (17'(cmd.char_code) < 17'(ccs_pkg::CHAR_COUNT));
    assign lit_in_range  = (17'(cmd.lit_index) < 17'(LM));
    assign lit_wr_idx    = IW'(cmd.lit_index);

    assign result.valid        = out_valid_reg;
    assign result.success      = out_success_reg;
    assign result.match_length = out_len_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_mode_reg      <= ccs_pkg::MODE_SPAN;
            literal_length_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ccs_pkg::CFG_SCAN_MODE: scan_mode_reg      <= cfg_data[ccs_pkg::MODE_W-1:0];
                ccs_pkg::CFG_LIT_LEN:   literal_length_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    // class table: written and read at the command transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (cmd.opcode == ccs_pkg::OP_WR_CLASS && char_in_range)
            begin
                class_mem[tbl_idx] <= cmd.class_bits;
            end
            cls_rd_reg <= class_mem[tbl_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_vld_reg  <= '0;
            cls_vld_rd_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (cmd.opcode == ccs_pkg::OP_WR_CLASS && char_in_range)
            begin
                class_vld_reg[tbl_idx] <= 1'b1;
            end
            cls_vld_rd_reg <= class_vld_reg[tbl_idx] && char_in_range;
        end
    end

    // literal store
    always_ff @(posedge clk)
    begin
        if (accept && cmd.opcode == ccs_pkg::OP_WR_LIT && lit_in_range)
        begin
            lit_reg[lit_wr_idx] <= cmd.char_code;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg.opcode     <= cmd.opcode;
            s1_item_reg.char_code  <= cmd.char_code;
            s1_item_reg.class_bits <= cmd.class_bits;
            s1_item_reg.lit_index  <= cmd.lit_index;
            s1_item_reg.at_end     <= cmd.at_end;
            s1_item_reg.last       <= cmd.last;
        end
    end

    // scan step
    always_comb
    begin
        logic [ccs_pkg::CLASS_W-1:0] cls;
        logic                        in_scan;
        logic                        opn;
        logic                        cls_close;
        logic [PW-1:0]               lit_l;
        logic [PW-1:0]               pos_inc;
        logic [PW-1:0]               win_pos;
        logic                        match;
        logic [ccs_pkg::CHAR_W-1:0]  ch;

        ch        = s1_item_reg.char_code;
        cls       = cls_vld_rd_reg ? cls_rd_reg : '0;
        in_scan   = cls[ccs_pkg::CLS_SCAN];
        opn       = cls[ccs_pkg::CLS_OPEN];
        cls_close = cls[ccs_pkg::CLS_CLOSE];
        lit_l     = (PW'(literal_length_reg) > PW'(LM)) ? PW'(LM) : PW'(literal_length_reg);
        pos_inc   = (pos_reg == PW'(ccs_pkg::SUBJECT_MAX)) ? pos_reg : pos_reg + 1'b1;

        // window after shifting in the current character
        for (int j = 0; j < LM - 1; j++)
        begin
            window_next[j] = window_reg[j + 1];
        end
        window_next[LM-1] = ch;

        // last lit_l window entries against the literal
        match = 1'b1;
        for (int i = 0; i < LM; i++)
        begin
            win_pos = PW'(LM) - lit_l + PW'(i);
            if (PW'(i) < lit_l && window_next[win_pos[IW-1:0]] != lit_reg[i])
            begin
                match = 1'b0;
            end
        end

        pos_next     = pos_reg;
        depth_next   = depth_reg;
        pending_next = pending_reg;
        decided_next = decided_reg;
        emit         = 1'b0;
        emit_ok      = 1'b0;
        emit_len     = '0;

        case (s1_item_reg.opcode)
            ccs_pkg::OP_START:
            begin
                pos_next     = '0;
                depth_next   = '0;
                pending_next = 1'b0;
                decided_next = 1'b0;
                for (int j = 0; j < LM; j++)
                begin
                    window_next[j] = '0;
                end
                case (scan_mode_reg)
                    ccs_pkg::MODE_ANY, ccs_pkg::MODE_SPAN,
                    ccs_pkg::MODE_BREAK, ccs_pkg::MODE_BAL:
                    begin
                        emit = s1_item_reg.at_end;
                    end
                    ccs_pkg::MODE_FIND, ccs_pkg::MODE_LIT:
                    begin
                        // empty literal matches at once, even at the end
                        if (lit_l == '0)
                        begin
                            emit    = 1'b1;
                            emit_ok = 1'b1;
                        end
                        else
                        begin
                            emit = s1_item_reg.at_end;
                        end
                    end
                    default:
                    begin
                        emit = 1'b1;
                    end
                endcase
            end
            ccs_pkg::OP_SUBJECT:
            begin
                if (!decided_reg)
                begin
                    case (scan_mode_reg)
                        ccs_pkg::MODE_ANY:
                        begin
                            emit     = 1'b1;
                            emit_ok  = in_scan;
                            emit_len = PW'(1);
                        end
                        ccs_pkg::MODE_SPAN:
                        begin
                            if (!in_scan)
                            begin
                                emit     = 1'b1;
                                emit_ok  = (pos_reg != '0);
                                emit_len = pos_reg;
                            end
                            else
                            begin
                                pos_next = pos_inc;
                                if (s1_item_reg.last)
                                begin
                                    emit     = 1'b1;
                                    emit_ok  = 1'b1;
                                    emit_len = pos_inc;
                                end
                            end
                        end
                        ccs_pkg::MODE_BREAK:
                        begin
                            if (in_scan)
                            begin
                                emit     = 1'b1;
                                emit_ok  = 1'b1;
                                emit_len = pos_reg;
                            end
                            else
                            begin
                                pos_next = pos_inc;
                                emit     = s1_item_reg.last;
                            end
                        end
                        ccs_pkg::MODE_BAL:
                        begin
                            if (pending_reg && in_scan)
                            begin
                                emit     = 1'b1;
                                emit_ok  = 1'b1;
                                emit_len = pos_reg;
                            end
                            else if (cls_close && !opn && depth_reg == '0)
                            begin
                                // close below depth zero
                                emit = 1'b1;
                            end
                            else
                            begin
                                if (opn && !cls_close)
                                begin
                                    if (depth_reg != ccs_pkg::DEPTH_MAX)
                                    begin
                                        depth_next = depth_reg + 1'b1;
                                    end
                                end
                                else if (cls_close && !opn)
                                begin
                                    depth_next = depth_reg - 1'b1;
                                end
                                pending_next = (depth_next == '0);
                                pos_next     = pos_inc;
                                emit         = s1_item_reg.last;
                            end
                        end
                        ccs_pkg::MODE_FIND:
                        begin
                            pos_next = pos_inc;
                            if (pos_inc >= lit_l && match)
                            begin
                                emit     = 1'b1;
                                emit_ok  = 1'b1;
                                emit_len = pos_inc - lit_l;
                            end
                            else
                            begin
                                emit = s1_item_reg.last;
                            end
                        end
                        ccs_pkg::MODE_LIT:
                        begin
                            if (pos_reg >= lit_l || ch != lit_reg[pos_reg[IW-1:0]])
                            begin
                                emit = 1'b1;
                            end
                            else
                            begin
                                pos_next = pos_inc;
                                if (pos_inc == lit_l)
                                begin
                                    emit     = 1'b1;
                                    emit_ok  = 1'b1;
                                    emit_len = lit_l;
                                end
                                else
                                begin
                                    emit = s1_item_reg.last;
                                end
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            default:
            begin
                // table and literal writes took effect at the transfer
            end
        endcase

        if (emit)
        begin
            decided_next = 1'b1;
        end
    end

    // scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            depth_reg   <= '0;
            pending_reg <= 1'b0;
            decided_reg <= 1'b1;
            for (int j = 0; j < LM; j++)
            begin
                window_reg[j] <= '0;
            end
        end
        else if (adv)
        begin
            pos_reg     <= pos_next;
            depth_reg   <= depth_next;
            pending_reg <= pending_next;
            decided_reg <= decided_next;
            if (s1_item_reg.opcode == ccs_pkg::OP_START ||
                (s1_item_reg.opcode == ccs_pkg::OP_SUBJECT && !decided_reg &&
                 scan_mode_reg == ccs_pkg::MODE_FIND))
            begin
                for (int j = 0; j < LM; j++)
                begin
                    window_reg[j] <= window_next[j];
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && emit)
        begin
            out_success_reg <= emit_ok;
            out_len_reg     <= emit_ok ? ccs_pkg::MLEN_W'(emit_len) : '0;
        end
    end

`ifndef SYNTH
    a_fail_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_success_reg) |-> (out_len_reg == '0))
        else $error("failed scan with nonzero match length");

    a_result_decides: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && emit) |=> decided_reg)
        else $error("scan not decided after a result");

    a_pending_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> (depth_reg == '0))
        else $error("pending zero with nonzero depth");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(ccs_pkg::SUBJECT_MAX))
        else $error("position beyond subject limit");

    a_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> (s1_valid_reg && out_valid_reg && !result.ready))
        else $error("command channel stalled without a held result");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for char_class_scan_engine. A queue of commands,
// register writes and drain points feeds a clocked driver. Both channels
// idle and stall at random. A monitor runs every accepted command through a
// cycle-free scan predictor and checks each result transfer in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SETTLE_CYCLES    = 4;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int LONG_HOLD_AFTER  = 60;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS     = 1850;
    localparam int TAIL_CYCLES      = 8;

    localparam logic [ccs_pkg::MODE_W-1:0] MODE_UNKNOWN_LO = 3'd6;
    localparam logic [ccs_pkg::MODE_W-1:0] MODE_UNKNOWN_HI = 3'd7;

    localparam logic [ccs_pkg::CLASS_W-1:0] CLS_NONE       = 3'b000;
    localparam logic [ccs_pkg::CLASS_W-1:0] CLS_SCAN_ONLY  = 3'b001;
    localparam logic [ccs_pkg::CLASS_W-1:0] CLS_OPEN_ONLY  = 3'b010;
    localparam logic [ccs_pkg::CLASS_W-1:0] CLS_CLOSE_ONLY = 3'b100;
    localparam logic [ccs_pkg::CLASS_W-1:0] CLS_ALL        = 3'b111;

    localparam logic [ccs_pkg::CHAR_W-1:0] CH_A     = 8'h61;
    localparam logic [ccs_pkg::CHAR_W-1:0] CH_B     = 8'h62;
    localparam logic [ccs_pkg::CHAR_W-1:0] CH_X     = 8'h78;
    localparam logic [ccs_pkg::CHAR_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [ccs_pkg::CHAR_W-1:0] CH_CLOSE = 8'h29;

    localparam int LM = ccs_pkg::LITERAL_MAX;

    typedef enum logic [1:0] {ACT_CMD, ACT_CFG, ACT_DRAIN} act_kind_t;

    typedef struct {
        act_kind_t                           kind;
        ccs_pkg::cmd_item_t                  cmd;
        logic [ccs_pkg::CFG_IDX_W-1:0]       reg_index;
        logic [ccs_pkg::CFG_DAT_W-1:0]       reg_value;
        int unsigned                         gap;
    } stim_action_t;

    typedef struct packed {
        logic                         success;
        logic [ccs_pkg::MLEN_W-1:0]   match_length;
    } scan_outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // block inputs, all known from time zero
    logic                          cmd_valid   = 1'b0;
    ccs_pkg::cmd_item_t            cmd_word    = '0;
    logic                          res_ready   = 1'b0;
    logic                          cfg_write_r = 1'b0;
    logic [ccs_pkg::CFG_IDX_W-1:0] cfg_index_r = '0;
    logic [ccs_pkg::CFG_DAT_W-1:0] cfg_data_r  = '0;

    ccs_cmd_if    cmd_ch ();
    ccs_result_if res_ch ();

    assign cmd_ch.valid      = cmd_valid;
    assign cmd_ch.opcode     = cmd_word.opcode;
    assign cmd_ch.char_code  = cmd_word.char_code;
    assign cmd_ch.class_bits = cmd_word.class_bits;
    assign cmd_ch.lit_index  = cmd_word.lit_index;
    assign cmd_ch.at_end     = cmd_word.at_end;
    assign cmd_ch.last       = cmd_word.last;
    assign res_ch.ready      = res_ready;

    char_class_scan_engine dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write_r),
        .cfg_index (cfg_index_r),
        .cfg_data  (cfg_data_r),
        .cmd       (cmd_ch),
        .result    (res_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // scan predictor state
    // ------------------------------------------------------------------
    logic [ccs_pkg::CLASS_W-1:0]  cls_table   [ccs_pkg::CHAR_COUNT] = '{default: '0};
    logic [ccs_pkg::CHAR_W-1:0]   lit_chars   [LM] = '{default: '0};
    logic [ccs_pkg::CHAR_W-1:0]   tail_window [LM] = '{default: '0};
    int unsigned                  scan_pos       = 0;
    logic [ccs_pkg::DEPTH_W-1:0]  bal_depth      = '0;
    bit                           depth_was_zero = 1'b0;
    bit                           scan_done      = 1'b1;
    logic [ccs_pkg::MODE_W-1:0]   cur_mode       = ccs_pkg::MODE_SPAN;
    logic [ccs_pkg::LITLEN_W-1:0] cur_litlen     = '0;

    scan_outcome_t awaited_outcomes[$];
    stim_action_t  pending_actions[$];

    int  mismatch_count = 0;
    int  cmd_xfers      = 0;
    int  res_xfers      = 0;
    int  queued_items   = 0;
    bit  sender_calm    = 1'b0;
    bit  long_hold_on   = 1'b0;
    bit  act_loaded     = 1'b0;
    bit  offering       = 1'b0;

    task automatic post_outcome(input logic ok, input int unsigned len);
        scan_outcome_t o;
        o.success      = ok;
        o.match_length = ok ? ccs_pkg::MLEN_W'(len) : '0;
        awaited_outcomes.push_back(o);
        scan_done = 1'b1;
    endtask

    task automatic advance_cursor();
        if (scan_pos < ccs_pkg::SUBJECT_MAX)
            scan_pos++;
    endtask

    task automatic model_command(input ccs_pkg::cmd_item_t c);
        int unsigned                 eff_len;
        logic [ccs_pkg::CLASS_W-1:0] cls;
        bit                          hit;
        bit                          opened;
        bit                          closed;
        eff_len = (cur_litlen > LM) ? LM : cur_litlen;
        case (c.opcode)
            ccs_pkg::OP_WR_CLASS: cls_table[c.char_code] = c.class_bits;
            ccs_pkg::OP_WR_LIT:   lit_chars[c.lit_index] = c.char_code;
            ccs_pkg::OP_START:
            begin
                scan_pos       = 0;
                bal_depth      = '0;
                depth_was_zero = 1'b0;
                tail_window    = '{default: '0};
                scan_done      = 1'b0;
                if (cur_mode > ccs_pkg::MODE_LIT)
                    post_outcome(1'b0, 0);
                else if ((cur_mode == ccs_pkg::MODE_FIND || cur_mode == ccs_pkg::MODE_LIT) &&
                         eff_len == 0)
                    post_outcome(1'b1, 0);
                else if (c.at_end)
                    post_outcome(1'b0, 0);
            end
            ccs_pkg::OP_SUBJECT:
            begin
                if (!scan_done)
                begin
                    cls = cls_table[c.char_code];
                    case (cur_mode)
                        ccs_pkg::MODE_ANY: post_outcome(cls[ccs_pkg::CLS_SCAN], 1);
                        ccs_pkg::MODE_SPAN:
                        begin
                            if (!cls[ccs_pkg::CLS_SCAN])
                                post_outcome(scan_pos != 0, scan_pos);
                            else
                            begin
                                advance_cursor();
                                if (c.last)
                                    post_outcome(1'b1, scan_pos);
                            end
                        end
                        ccs_pkg::MODE_BREAK:
                        begin
                            if (cls[ccs_pkg::CLS_SCAN])
                                post_outcome(1'b1, scan_pos);
                            else
                            begin
                                advance_cursor();
                                if (c.last)
                                    post_outcome(1'b0, 0);
                            end
                        end
                        ccs_pkg::MODE_BAL:
                        begin
                            opened = cls[ccs_pkg::CLS_OPEN] && !cls[ccs_pkg::CLS_CLOSE];
                            closed = cls[ccs_pkg::CLS_CLOSE] && !cls[ccs_pkg::CLS_OPEN];
                            if (depth_was_zero && cls[ccs_pkg::CLS_SCAN])
                                post_outcome(1'b1, scan_pos);
                            else if (closed && bal_depth == 0)
                                post_outcome(1'b0, 0);
                            else
                            begin
                                if (opened && bal_depth != ccs_pkg::DEPTH_MAX)
                                    bal_depth++;
                                else if (closed)
                                    bal_depth--;
                                depth_was_zero = (bal_depth == 0);
                                advance_cursor();
                                if (c.last)
                                    post_outcome(1'b0, 0);
                            end
                        end
                        ccs_pkg::MODE_FIND:
                        begin
                            for (int i = 0; i < LM - 1; i++)
                                tail_window[i] = tail_window[i + 1];
                            tail_window[LM - 1] = c.char_code;
                            advance_cursor();
                            hit = 1'b0;
                            if (scan_pos >= eff_len)
                            begin
                                hit = 1'b1;
                                for (int i = 0; i < eff_len; i++)
                                    if (tail_window[LM - eff_len + i] != lit_chars[i])
                                        hit = 1'b0;
                            end
                            if (hit)
                                post_outcome(1'b1, scan_pos - eff_len);
                            else if (c.last)
                                post_outcome(1'b0, 0);
                        end
                        ccs_pkg::MODE_LIT:
                        begin
                            if (scan_pos >= eff_len)
                                post_outcome(1'b0, 0);
                            else if (c.char_code != lit_chars[scan_pos])
                                post_outcome(1'b0, 0);
                            else
                            begin
                                advance_cursor();
                                if (scan_pos == eff_len)
                                    post_outcome(1'b1, eff_len);
                                else if (c.last)
                                    post_outcome(1'b0, 0);
                            end
                        end
                        default: post_outcome(1'b0, 0);
                    endcase
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // command driver
    // ------------------------------------------------------------------
    stim_action_t cur_act;
    int unsigned  gap_left = 0;
    int unsigned  settle   = 0;
    int           cmds_sent = 0;

    always @(negedge clk)
    begin : drive_cmd
        logic next_valid;
        logic next_cfg;
        next_valid = cmd_valid;
        next_cfg   = 1'b0;
        if (rst_n)
        begin
            if (offering && cmd_xfers != cmds_sent)
            begin
                cmds_sent  = cmd_xfers;
                offering   = 1'b0;
                next_valid = 1'b0;
            end
            if (!offering)
            begin
                if (!act_loaded && pending_actions.size() != 0)
                begin
                    cur_act    = pending_actions.pop_front();
                    act_loaded = 1'b1;
                    gap_left   = cur_act.gap;
                    settle     = 0;
                end
                if (act_loaded)
                begin
                    if (cur_act.kind == ACT_CMD)
                    begin
                        // no gaps while the receiver holds off, so the block fills up
                        if (gap_left != 0 && !long_hold_on)
                            gap_left--;
                        else
                        begin
                            cmd_word   <= cur_act.cmd;
                            next_valid = 1'b1;
                            offering   = 1'b1;
                            act_loaded = 1'b0;
                        end
                    end
                    else if (awaited_outcomes.size() != 0)
                        settle = 0;
                    else if (settle < SETTLE_CYCLES)
                        settle++;
                    else
                    begin
                        if (cur_act.kind == ACT_CFG)
                        begin
                            next_cfg = 1'b1;
                            cfg_index_r <= cur_act.reg_index;
                            cfg_data_r  <= cur_act.reg_value;
                        end
                        act_loaded = 1'b0;
                    end
                end
            end
        end
        cmd_valid   <= next_valid;
        cfg_write_r <= next_cfg;
    end

    // ------------------------------------------------------------------
    // result receiver
    // ------------------------------------------------------------------
    int  res_seen       = 0;
    int  stall_left     = 0;
    int  sink_cycles    = 0;
    bit  long_hold_done = 1'b0;

    always @(negedge clk)
    begin : drive_ready
        if (rst_n)
        begin
            sink_cycles++;
            if (res_xfers != res_seen)
            begin
                res_seen = res_xfers;
                if (!long_hold_done && res_xfers >= LONG_HOLD_AFTER)
                begin
                    stall_left     = LONG_HOLD_CYCLES;
                    long_hold_done = 1'b1;
                    long_hold_on   = 1'b1;
                end
                else if (sink_cycles % 1000 < 250)
                    stall_left = 0;
                else
                    stall_left = $urandom_range(0, 16);
            end
            if (stall_left != 0)
            begin
                stall_left--;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready    <= 1'b1;
                long_hold_on = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor and checker
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk)
    begin : watch_channels
        scan_outcome_t want;
        bit            moved;
        if (rst_n)
        begin
            moved = 1'b0;
            // check before predicting: a command never returns in its own cycle
            if (res_ch.valid && res_ch.ready)
            begin
                moved = 1'b1;
                res_xfers++;
                if (awaited_outcomes.size() == 0)
                begin
                    $error("unexpected result transfer: success=%0b match_length=%0d",
                           res_ch.success, res_ch.match_length);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (res_ch.success !== want.success)
                    begin
                        $error("success: expected %0b, got %0b", want.success, res_ch.success);
                        mismatch_count++;
                    end
                    if (res_ch.match_length !== want.match_length)
                    begin
                        $error("match_length: expected %0d, got %0d",
                               want.match_length, res_ch.match_length);
                        mismatch_count++;
                    end
                end
            end
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                moved = 1'b1;
                cmd_xfers++;
                model_command(cmd_word);
            end
            if (cfg_write_r)
            begin
                moved = 1'b1;
                if (cfg_index_r == ccs_pkg::CFG_SCAN_MODE)
                    cur_mode = cfg_data_r[ccs_pkg::MODE_W-1:0];
                else if (cfg_index_r == ccs_pkg::CFG_LIT_LEN)
                    cur_litlen = cfg_data_r[ccs_pkg::LITLEN_W-1:0];
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic queue_cmd(input logic [ccs_pkg::OPCODE_W-1:0] op,
                             input logic [ccs_pkg::CHAR_W-1:0] ch,
                             input logic [ccs_pkg::CLASS_W-1:0] bits,
                             input logic [ccs_pkg::LIT_IN_W-1:0] idx,
                             input logic ae, input logic lst);
        stim_action_t a;
        a.kind           = ACT_CMD;
        a.cmd.opcode     = op;
        a.cmd.char_code  = ch;
        a.cmd.class_bits = bits;
        a.cmd.lit_index  = idx;
        a.cmd.at_end     = ae;
        a.cmd.last       = lst;
        a.reg_index      = '0;
        a.reg_value      = '0;
        a.gap            = sender_calm ? 0 : $urandom_range(0, 16);
        pending_actions.push_back(a);
        queued_items++;
    endtask

    task automatic put_class(input logic [ccs_pkg::CHAR_W-1:0] ch,
                             input logic [ccs_pkg::CLASS_W-1:0] bits);
        queue_cmd(ccs_pkg::OP_WR_CLASS, ch, bits, ccs_pkg::LIT_IN_W'($urandom),
                  1'($urandom), 1'($urandom));
    endtask

    task automatic put_lit(input logic [ccs_pkg::LIT_IN_W-1:0] idx,
                           input logic [ccs_pkg::CHAR_W-1:0] ch);
        queue_cmd(ccs_pkg::OP_WR_LIT, ch, ccs_pkg::CLASS_W'($urandom), idx,
                  1'($urandom), 1'($urandom));
    endtask

    task automatic put_start(input logic ae);
        queue_cmd(ccs_pkg::OP_START, ccs_pkg::CHAR_W'($urandom), ccs_pkg::CLASS_W'($urandom),
                  ccs_pkg::LIT_IN_W'($urandom), ae, 1'($urandom));
    endtask

    task automatic put_char(input logic [ccs_pkg::CHAR_W-1:0] ch, input logic lst);
        queue_cmd(ccs_pkg::OP_SUBJECT, ch, ccs_pkg::CLASS_W'($urandom),
                  ccs_pkg::LIT_IN_W'($urandom), 1'($urandom), lst);
    endtask

    task automatic queue_cfg(input logic [ccs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ccs_pkg::CFG_DAT_W-1:0] val);
        stim_action_t a;
        a.kind      = ACT_CFG;
        a.cmd       = '0;
        a.reg_index = idx;
        a.reg_value = val;
        a.gap       = 0;
        pending_actions.push_back(a);
    endtask

    task automatic queue_drain();
        stim_action_t a;
        a.kind      = ACT_DRAIN;
        a.cmd       = '0;
        a.reg_index = '0;
        a.reg_value = '0;
        a.gap       = 0;
        pending_actions.push_back(a);
    endtask

    initial
    begin : stimulus
        logic [ccs_pkg::CHAR_W-1:0] alpha    [8];
        logic [ccs_pkg::CHAR_W-1:0] lit_word [LM];
        logic [ccs_pkg::CHAR_W-1:0] word     [64];
        int  mode_pick;
        int  len_pick;
        int  lit_n;
        int  n;
        int  off;
        int  item_goal;
        bit  cut;
        bit  fresh_cfg;

        // directed: one of each primitive and the corner cases
        put_class(CH_A, CLS_SCAN_ONLY);
        put_class(CH_OPEN, CLS_OPEN_ONLY);
        put_class(CH_CLOSE, CLS_CLOSE_ONLY);
        put_class(8'hFF, CLS_ALL);
        put_class(8'h00, CLS_NONE);
        // span is the mode out of reset
        put_start(1'b0);
        put_char(CH_A, 1'b0);
        put_char(CH_A, 1'b0);
        put_char(CH_B, 1'b0);
        put_start(1'b1);
        queue_cfg(ccs_pkg::CFG_SCAN_MODE, ccs_pkg::CFG_DAT_W'(ccs_pkg::MODE_ANY));
        put_start(1'b0);
        put_char(8'h00, 1'b1);
        put_char(8'hFF, 1'b0);
        queue_cfg(ccs_pkg::CFG_SCAN_MODE, ccs_pkg::CFG_DAT_W'(ccs_pkg::MODE_BREAK));
        put_start(1'b0);
        put_char(CH_B, 1'b0);
        put_char(CH_A, 1'b0);
        queue_cfg(ccs_pkg::CFG_SCAN_MODE, ccs_pkg::CFG_DAT_W'(ccs_pkg::MODE_BAL));
        put_start(1'b0);
        put_char(CH_OPEN, 1'b0);
        put_char(CH_CLOSE, 1'b0);
        put_char(CH_A, 1'b0);
        // closing at depth zero
        put_start(1'b0);
        put_char(CH_CLOSE, 1'b0);
        // empty literal succeeds at start
        queue_cfg(ccs_pkg::CFG_SCAN_MODE, ccs_pkg::CFG_DAT_W'(ccs_pkg::MODE_FIND));
        put_start(1'b0);
        put_lit(4'd0, CH_A);
        put_lit(4'd1, CH_B);
        queue_cfg(ccs_pkg::CFG_LIT_LEN, ccs_pkg::CFG_DAT_W'(2));
        put_start(1'b0);
        put_char(CH_X, 1'b0);
        put_char(CH_A, 1'b0);
        put_char(CH_B, 1'b1);
        queue_cfg(ccs_pkg::CFG_SCAN_MODE, ccs_pkg::CFG_DAT_W'(ccs_pkg::MODE_LIT));
        put_start(1'b0);
        put_char(CH_A, 1'b0);
        put_char(CH_B, 1'b0);
        queue_cfg(ccs_pkg::CFG_SCAN_MODE, ccs_pkg::CFG_DAT_W'(MODE_UNKNOWN_LO));
        put_start(1'b0);
        queue_cfg(ccs_pkg::CFG_SCAN_MODE, ccs_pkg::CFG_DAT_W'(MODE_UNKNOWN_HI));
        put_start(1'b0);

        // random sessions over a small alphabet so that classes and literals recur
        for (int k = 0; k < 8; k++)
        begin
            alpha[k] = ccs_pkg::CHAR_W'($urandom);
            put_class(alpha[k], ccs_pkg::CLASS_W'($urandom));
        end
        lit_n       = 2;
        lit_word[0] = CH_A;
        lit_word[1] = CH_B;
        mode_pick   = MODE_UNKNOWN_HI;
        fresh_cfg   = 1'b1;
        item_goal   = queued_items + RANDOM_ITEMS;
        while (queued_items < item_goal)
        begin
            if ($urandom_range(0, 7) == 0)
                sender_calm = !sender_calm;
            if (fresh_cfg || $urandom_range(0, 5) == 0)
            begin
                fresh_cfg = 1'b0;
                mode_pick = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 7)
                                                         : $urandom_range(0, 5);
                case ($urandom_range(0, 9))
                    0:       len_pick = 0;
                    1:       len_pick = LM;
                    2:       len_pick = $urandom_range(LM + 1, 31);
                    default: len_pick = $urandom_range(1, 4);
                endcase
                lit_n = (len_pick > LM) ? LM : len_pick;
                for (int i = 0; i < lit_n; i++)
                begin
                    lit_word[i] = alpha[$urandom_range(0, 3)];
                    put_lit(ccs_pkg::LIT_IN_W'(i), lit_word[i]);
                end
                // upper data bits are don't-care for the mode register
                queue_cfg(ccs_pkg::CFG_SCAN_MODE,
                          ccs_pkg::CFG_DAT_W'(($urandom_range(0, 3) << ccs_pkg::MODE_W) |
                                              mode_pick));
                queue_cfg(ccs_pkg::CFG_LIT_LEN, ccs_pkg::CFG_DAT_W'(len_pick));
            end
            if ($urandom_range(0, 19) == 0)
                put_class(alpha[$urandom_range(0, 7)], ccs_pkg::CLASS_W'($urandom));
            put_start($urandom_range(0, 9) == 0);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
                word[i] = ($urandom_range(0, 4) == 0) ? ccs_pkg::CHAR_W'($urandom)
                                                      : alpha[$urandom_range(0, 7)];
            if ((mode_pick == ccs_pkg::MODE_FIND || mode_pick == ccs_pkg::MODE_LIT) &&
                lit_n > 0 && $urandom_range(0, 1) == 1)
            begin
                off = (mode_pick == ccs_pkg::MODE_LIT) ? 0 : $urandom_range(0, 3);
                if (n < off + lit_n)
                    n = off + lit_n;
                for (int i = 0; i < lit_n; i++)
                    word[off + i] = lit_word[i];
                // near miss
                if ($urandom_range(0, 3) == 0)
                    word[off + $urandom_range(0, lit_n - 1)] = ccs_pkg::CHAR_W'($urandom);
            end
            // an unfinished subject gets abandoned by the next start
            cut = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 29) == 0)
                begin
                    if ($urandom_range(0, 1) == 0)
                        put_class(alpha[$urandom_range(0, 7)], ccs_pkg::CLASS_W'($urandom));
                    else
                        put_lit(ccs_pkg::LIT_IN_W'($urandom), ccs_pkg::CHAR_W'($urandom));
                end
                put_char(word[i], (i == n - 1) && !cut);
            end
            if ($urandom_range(0, 9) == 0)
                put_char(ccs_pkg::CHAR_W'($urandom), 1'($urandom));
            if ($urandom_range(0, 11) == 0)
                queue_drain();
        end

        // full literal with an oversized length setting
        sender_calm = 1'b1;
        for (int i = 0; i < LM; i++)
            put_lit(ccs_pkg::LIT_IN_W'(i), ccs_pkg::CHAR_W'(i * 17));
        queue_cfg(ccs_pkg::CFG_LIT_LEN, ccs_pkg::CFG_DAT_W'(31));
        queue_cfg(ccs_pkg::CFG_SCAN_MODE, ccs_pkg::CFG_DAT_W'(ccs_pkg::MODE_LIT));
        put_start(1'b0);
        for (int i = 0; i < LM; i++)
            put_char(ccs_pkg::CHAR_W'(i * 17), 1'b0);
        queue_cfg(ccs_pkg::CFG_SCAN_MODE, ccs_pkg::CFG_DAT_W'(ccs_pkg::MODE_FIND));
        put_start(1'b0);
        for (int i = 0; i < LM; i++)
            put_char(ccs_pkg::CHAR_W'(i * 17), i == LM - 1);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_actions.size() != 0 || act_loaded || offering ||
               awaited_outcomes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && awaited_outcomes.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ccs_pkg.sv
rtl/ccs_if.sv
rtl/char_class_scan_engine.sv
test/tb_top.sv
